### design/mhf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes, types and arithmetic helpers for the scaled HMM forward block.
// No dependencies; mhf_ctrl, mhf_dp and the top level import this package.
package mhf_pkg;

  localparam int MAX_STATE_COUNT_DEF = 128;
  localparam int MAX_MOTIF_COUNT_DEF = 4;
  localparam int FRAC_BITS_DEF       = 31;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 4;
  localparam int IN_DW  = 56;
  localparam int OUT_DW = 32;
  localparam int LAYW   = 8;
  localparam int ESW    = 36;

  localparam logic [1:0] CMD_LOAD_EMIS  = 2'd0;
  localparam logic [1:0] CMD_LOAD_START = 2'd1;
  localparam logic [1:0] CMD_FIRST      = 2'd2;
  localparam logic [1:0] CMD_NEXT       = 2'd3;

  localparam logic [2:0] REG_NUM_MOTIFS = 3'd0;
  localparam logic [2:0] REG_WIDTH_0    = 3'd1;
  localparam logic [2:0] REG_WIDTH_1    = 3'd2;
  localparam logic [2:0] REG_WIDTH_2    = 3'd3;
  localparam logic [2:0] REG_WIDTH_3    = 3'd4;

  localparam logic [1:0] ROLE_BKG   = 2'd0;
  localparam logic [1:0] ROLE_START = 2'd1;
  localparam logic [1:0] ROLE_CONT  = 2'd2;

  localparam logic [2:0] SYM_A       = 3'd0;
  localparam logic [2:0] SYM_C       = 3'd1;
  localparam logic [2:0] SYM_G       = 3'd2;
  localparam logic [2:0] SYM_T       = 3'd3;
  localparam logic [2:0] SYM_UNKNOWN = 3'd4;

  localparam logic [7:0] CHR_A_LO = 8'h61;
  localparam logic [7:0] CHR_A_UP = 8'h41;
  localparam logic [7:0] CHR_C_LO = 8'h63;
  localparam logic [7:0] CHR_C_UP = 8'h43;
  localparam logic [7:0] CHR_G_LO = 8'h67;
  localparam logic [7:0] CHR_G_UP = 8'h47;
  localparam logic [7:0] CHR_T_LO = 8'h74;
  localparam logic [7:0] CHR_T_UP = 8'h54;
  localparam logic [7:0] CHR_U_LO = 8'h75;
  localparam logic [7:0] CHR_U_UP = 8'h55;

  localparam int SW = 5;
  localparam logic [SW-1:0] ST_IDLE  = 5'd0;
  localparam logic [SW-1:0] ST_F_RD  = 5'd1;
  localparam logic [SW-1:0] ST_F_MUL = 5'd2;
  localparam logic [SW-1:0] ST_F_WR  = 5'd3;
  localparam logic [SW-1:0] ST_N_A0  = 5'd4;
  localparam logic [SW-1:0] ST_N_A0L = 5'd5;
  localparam logic [SW-1:0] ST_N_ER  = 5'd6;
  localparam logic [SW-1:0] ST_N_EA  = 5'd7;
  localparam logic [SW-1:0] ST_N_RD  = 5'd8;
  localparam logic [SW-1:0] ST_N_M1  = 5'd9;
  localparam logic [SW-1:0] ST_N_ADD = 5'd10;
  localparam logic [SW-1:0] ST_N_M2  = 5'd11;
  localparam logic [SW-1:0] ST_N_WR  = 5'd12;
  localparam logic [SW-1:0] ST_D_RD  = 5'd13;
  localparam logic [SW-1:0] ST_D_LD  = 5'd14;
  localparam logic [SW-1:0] ST_D_IT  = 5'd15;
  localparam logic [SW-1:0] ST_D_WR  = 5'd16;
  localparam logic [SW-1:0] ST_OUT   = 5'd17;

  typedef struct packed {
    logic [SW-1:0] state;
    logic [1:0]    role;
    logic [1:0]    motif;
    logic          in_range;
    logic          div_first;
    logic          out_load;
  } mhf_cmd_t;

  function automatic logic [31:0] qmul(logic [31:0] a, logic [31:0] b, int fb);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    p = p >> fb;
    return (|p[63:32]) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic logic [2:0] sym_of(logic [7:0] c);
    logic [2:0] s;
    unique case (c)
      CHR_A_LO, CHR_A_UP: s = SYM_A;
      CHR_C_LO, CHR_C_UP: s = SYM_C;
      CHR_G_LO, CHR_G_UP: s = SYM_G;
      CHR_T_LO, CHR_T_UP, CHR_U_LO, CHR_U_UP: s = SYM_T;
      default: s = SYM_UNKNOWN;
    endcase
    return s;
  endfunction

endpackage

### design/mhf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/mhf_ctrl.sv
`timescale 1ns / 1ps
// Controller: configuration registers, model layout walk, sequencing state machine.
// Depends on mhf_pkg; drives mhf_dp through the command struct.
module mhf_ctrl #(
  parameter int MSC = 128,
  parameter int MMC = 4,
  parameter int FB  = 31,
  localparam int SIW = $clog2(MSC)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [mhf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mhf_pkg::CFG_DW-1:0] cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [1:0]                in_cmd,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      sum_zero,
  output mhf_pkg::mhf_cmd_t         cmd,
  output logic [SIW-1:0]            st_idx,
  output logic [SIW-1:0]            rd_idx
);
  import mhf_pkg::*;

  localparam int CNTW = $clog2(FB + 1);

  logic [SW-1:0]   state_r, state_nxt;
  logic [2:0]      num_motifs_r;
  logic [3:0]      width_r [4];
  logic [SIW-1:0]  j_r, j_nxt;
  logic [1:0]      m_r, m_nxt;
  logic            c_r, c_nxt;
  logic [3:0]      p_r, p_nxt;
  logic [LAYW-1:0] base_r, base_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [2:0]      nm_eff;
  logic [3:0]      weff [4];
  logic [LAYW-1:0] total, ns, e_idx;
  logic [3:0]      wcur;
  logic            j_in, e_ok, last_end, last_state, last_all, out_free, in_acc;
  logic [1:0]      wm_nxt;
  logic            wc_nxt;
  logic [3:0]      wp_nxt;

  always_comb begin
    if (num_motifs_r == 3'd0) begin
      nm_eff = 3'd1;
    end else if (32'(num_motifs_r) > MMC) begin
      nm_eff = 3'(MMC);
    end else begin
      nm_eff = num_motifs_r;
    end
    total = LAYW'(1);
    for (int k = 0; k < 4; k++) begin
      weff[k] = (width_r[k] == 4'd0) ? 4'd1 : width_r[k];
      if (k < 32'(nm_eff)) begin
        total = total + LAYW'({weff[k], 1'b0});
      end
    end
    ns = (32'(total) < MSC) ? total : LAYW'(MSC);
  end

  assign wcur       = weff[m_r];
  assign e_idx      = base_r + LAYW'(wcur) - LAYW'(1);
  assign e_ok       = 32'(e_idx) < 32'(ns);
  assign j_in       = 32'(j_r) < 32'(ns);
  assign last_end   = c_r && (3'(m_r) == nm_eff - 3'd1);
  assign last_state = (32'(j_r) + 1) == 32'(ns);
  assign last_all   = 32'(j_r) == (MSC - 1);
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    wm_nxt = m_r;
    wc_nxt = c_r;
    wp_nxt = p_r;
    if (j_r == '0) begin
      wm_nxt = '0;
      wc_nxt = 1'b0;
      wp_nxt = '0;
    end else if (p_r + 4'd1 == wcur) begin
      wp_nxt = '0;
      if (c_r) begin
        wc_nxt = 1'b0;
        wm_nxt = m_r + 2'd1;
      end else begin
        wc_nxt = 1'b1;
      end
    end else begin
      wp_nxt = p_r + 4'd1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        j_nxt = '0;
        if (in_acc && in_cmd == CMD_FIRST) begin
          state_nxt = ST_F_RD;
        end else if (in_acc && in_cmd == CMD_NEXT) begin
          state_nxt = ST_N_A0;
        end
      end
      ST_F_RD:  state_nxt = ST_F_MUL;
      ST_F_MUL: state_nxt = ST_F_WR;
      ST_F_WR: begin
        if (last_all) begin
          state_nxt = ST_OUT;
        end else begin
          j_nxt     = j_r + 1'b1;
          m_nxt     = wm_nxt;
          c_nxt     = wc_nxt;
          p_nxt     = wp_nxt;
          state_nxt = ST_F_RD;
        end
      end
      ST_N_A0: state_nxt = ST_N_A0L;
      ST_N_A0L: begin
        base_nxt  = LAYW'(1);
        m_nxt     = '0;
        c_nxt     = 1'b0;
        state_nxt = ST_N_ER;
      end
      ST_N_ER: state_nxt = ST_N_EA;
      ST_N_EA: begin
        if (last_end) begin
          j_nxt     = '0;
          m_nxt     = '0;
          c_nxt     = 1'b0;
          p_nxt     = '0;
          state_nxt = ST_N_RD;
        end else begin
          base_nxt = base_r + LAYW'(wcur);
          if (c_r) begin
            c_nxt = 1'b0;
            m_nxt = m_r + 2'd1;
          end else begin
            c_nxt = 1'b1;
          end
          state_nxt = ST_N_ER;
        end
      end
      ST_N_RD:  state_nxt = ST_N_M1;
      ST_N_M1:  state_nxt = ST_N_ADD;
      ST_N_ADD: state_nxt = ST_N_M2;
      ST_N_M2:  state_nxt = ST_N_WR;
      ST_N_WR: begin
        if (last_state) begin
          j_nxt     = '0;
          state_nxt = ST_D_RD;
        end else begin
          j_nxt     = j_r + 1'b1;
          m_nxt     = wm_nxt;
          c_nxt     = wc_nxt;
          p_nxt     = wp_nxt;
          state_nxt = ST_N_RD;
        end
      end
      ST_D_RD: begin
        state_nxt = (sum_zero || !j_in) ? ST_D_WR : ST_D_LD;
      end
      ST_D_LD: begin
        cnt_nxt   = '0;
        state_nxt = ST_D_IT;
      end
      ST_D_IT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(FB)) begin
          state_nxt = ST_D_WR;
        end
      end
      ST_D_WR: begin
        if (last_all) begin
          state_nxt = ST_OUT;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_D_RD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.state     = state_r;
    cmd.role      = (j_r == '0) ? ROLE_BKG : ((p_r == 4'd0) ? ROLE_START : ROLE_CONT);
    cmd.motif     = m_r;
    cmd.in_range  = (state_r == ST_N_ER || state_r == ST_N_EA) ? e_ok : j_in;
    cmd.div_first = (cnt_r == '0);
    cmd.out_load  = (state_r == ST_OUT) && out_free;
    st_idx        = j_r;
    if (state_r == ST_N_ER) begin
      rd_idx = SIW'(e_idx);
    end else if (state_r == ST_N_RD) begin
      rd_idx = j_r - 1'b1;
    end else begin
      rd_idx = j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_motifs_r <= 3'd1;
      for (int k = 0; k < 4; k++) begin
        width_r[k] <= 4'd1;
      end
      j_r         <= '0;
      m_r         <= '0;
      c_r         <= 1'b0;
      p_r         <= '0;
      base_r      <= LAYW'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      m_r         <= m_nxt;
      c_r         <= c_nxt;
      p_r         <= p_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_NUM_MOTIFS: num_motifs_r <= cfg_data[2:0];
          REG_WIDTH_0:    width_r[0]   <= cfg_data;
          REG_WIDTH_1:    width_r[1]   <= cfg_data;
          REG_WIDTH_2:    width_r[2]   <= cfg_data;
          REG_WIDTH_3:    width_r[3]   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  a_wr_in_layout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_N_WR) |-> j_in)
    else $error("state write beyond layout");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_D_IT) |-> (32'(cnt_r) <= FB))
    else $error("division ran past its bit count");

  a_motif_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_N_RD && j_r != '0) |-> (3'(m_r) < nm_eff))
    else $error("chain walk left the motif list");

  a_result_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not posted");

endmodule

### design/mhf_dp.sv
`timescale 1ns / 1ps
// Datapath: probability tables, alpha buffers, fixed-point multiply, sum and serial divider.
// Depends on mhf_pkg and mhf_ram; steered by the command struct from mhf_ctrl.
module mhf_dp #(
  parameter int MSC = 128,
  parameter int MMC = 4,
  parameter int FB  = 31,
  localparam int SIW = $clog2(MSC)
) (
  input  logic              clk,
  input  logic              in_accept,
  input  logic [1:0]        in_cmd,
  input  logic [8:0]        in_tix,
  input  logic [31:0]       in_val,
  input  logic [7:0]        in_nuc,
  input  mhf_pkg::mhf_cmd_t cmd,
  input  logic [SIW-1:0]    st_idx,
  input  logic [SIW-1:0]    rd_idx,
  output logic              sum_zero,
  output logic [31:0]       out_scale,
  output logic              out_zero
);
  import mhf_pkg::*;

  localparam int SD   = 2 + 2 * MMC;
  localparam int SAW  = $clog2(SD);
  localparam int ED   = 4 * MSC;
  localparam int EAW  = SIW + 2;
  localparam int SUMW = 32 + SIW;
  localparam logic [31:0] QONE     = 32'(64'd1 << FB);
  localparam logic [31:0] QQUARTER = 32'(64'd1 << (FB - 2));

  logic [31:0]     start_r [SD];
  logic [2:0]      sym_r;
  logic            first_r;
  logic [31:0]     a0_r, prod_r, v_r, a_r, q_r, scale_r;
  logic [ESW-1:0]  endsum_r;
  logic [SUMW-1:0] sum_r, rem_r;
  logic            zero_r;

  logic            e_we, a_we, a_re, b_re, e_re;
  logic [31:0]     e_rdata, a_rdata, b_rdata, a_wdata;
  logic [31:0]     prior_sel, trans_sel, emit_in, emit_out;
  logic [ESW-1:0]  bkg_sum;
  logic [SUMW:0]   div_t;
  logic            div_ge;
  int              pidx, tidx;

  assign e_we = in_accept && in_cmd == CMD_LOAD_EMIS && 32'(in_tix) < ED;
  assign e_re = cmd.state == ST_F_RD || cmd.state == ST_N_RD;
  assign a_we = cmd.state == ST_F_WR || cmd.state == ST_D_WR;
  assign a_re = cmd.state == ST_N_A0 || cmd.state == ST_N_ER || cmd.state == ST_N_RD;
  assign b_re = cmd.state == ST_D_RD;

  always_comb begin
    if (cmd.state == ST_F_WR) begin
      a_wdata = cmd.in_range ? prod_r : '0;
    end else begin
      a_wdata = (cmd.in_range && !sum_zero) ? q_r : '0;
    end
  end

  mhf_ram #(.WIDTH(32), .DEPTH(ED)) u_emis (
    .clk(clk), .we(e_we), .waddr(EAW'(in_tix)), .wdata(in_val),
    .re(e_re), .raddr({st_idx, sym_r[1:0]}), .rdata(e_rdata)
  );

  mhf_ram #(.WIDTH(32), .DEPTH(MSC)) u_alpha (
    .clk(clk), .we(a_we), .waddr(st_idx), .wdata(a_wdata),
    .re(a_re), .raddr(rd_idx), .rdata(a_rdata)
  );

  mhf_ram #(.WIDTH(32), .DEPTH(MSC)) u_next (
    .clk(clk), .we(cmd.state == ST_N_WR), .waddr(st_idx), .wdata(a_r),
    .re(b_re), .raddr(st_idx), .rdata(b_rdata)
  );

  always_comb begin
    pidx      = (cmd.role == ROLE_BKG) ? 1 : 3 + 2 * int'(cmd.motif);
    tidx      = (cmd.role == ROLE_BKG) ? 0 : 2 + 2 * int'(cmd.motif);
    prior_sel = '0;
    trans_sel = '0;
    for (int k = 0; k < SD; k++) begin
      if (k == pidx) prior_sel = start_r[k];
      if (k == tidx) trans_sel = start_r[k];
    end
    emit_in = (cmd.state == ST_F_MUL) ? prior_sel : v_r;
    if (sym_r == SYM_UNKNOWN) begin
      emit_out = emit_in;
    end else if (cmd.role == ROLE_BKG) begin
      emit_out = qmul(emit_in, QQUARTER, FB);
    end else begin
      emit_out = qmul(emit_in, e_rdata, FB);
    end
    bkg_sum = ESW'(prod_r) + endsum_r;
    div_t   = cmd.div_first ? {1'b0, rem_r} : {rem_r, 1'b0};
    div_ge  = div_t >= {1'b0, sum_r};
  end

  assign sum_zero  = (sum_r == '0);
  assign out_scale = scale_r;
  assign out_zero  = zero_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sym_r   <= sym_of(in_nuc);
      first_r <= (in_cmd == CMD_FIRST);
      if (in_cmd == CMD_LOAD_START && 32'(in_tix) < SD) begin
        start_r[in_tix[SAW-1:0]] <= in_val;
      end
    end
    case (cmd.state)
      ST_F_MUL: prod_r <= emit_out;
      ST_N_A0L: begin
        a0_r     <= a_rdata;
        endsum_r <= '0;
        sum_r    <= '0;
      end
      ST_N_EA: begin
        if (cmd.in_range) endsum_r <= endsum_r + ESW'(a_rdata);
      end
      ST_N_M1: prod_r <= qmul(a0_r, trans_sel, FB);
      ST_N_ADD: begin
        if (cmd.role == ROLE_BKG) begin
          v_r <= (|bkg_sum[ESW-1:32]) ? 32'hFFFF_FFFF : bkg_sum[31:0];
        end else if (cmd.role == ROLE_START) begin
          v_r <= prod_r;
        end else begin
          v_r <= a_rdata;
        end
      end
      ST_N_M2: a_r <= emit_out;
      ST_N_WR: sum_r <= sum_r + SUMW'(a_r);
      ST_D_LD: begin
        rem_r <= SUMW'(b_rdata);
        q_r   <= '0;
      end
      ST_D_IT: begin
        rem_r <= div_ge ? SUMW'(div_t - {1'b0, sum_r}) : SUMW'(div_t);
        q_r   <= {q_r[30:0], div_ge};
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      if (first_r) begin
        scale_r <= QONE;
        zero_r  <= 1'b0;
      end else begin
        scale_r <= (|sum_r[SUMW-1:32]) ? 32'hFFFF_FFFF : sum_r[31:0];
        zero_r  <= sum_zero;
      end
    end
  end

endmodule

### design/motif_hmm_forward_scaled.sv
`timescale 1ns / 1ps
// Scaled HMM forward recursion over a nucleotide stream: top level.
// Depends on mhf_pkg, mhf_ctrl, mhf_dp (which uses mhf_ram).
//
// Input stream: one request per command. tuser carries the command (load emission,
// load transition/prior, first nucleotide, next nucleotide); tdata carries the table
// index, the table word and the nucleotide byte. Loads take effect in the accept cycle
// and return nothing. Nucleotide commands return one result: tdata is the scale,
// tuser flags a zero sum (alpha cleared).
// A first nucleotide does one emission read and one multiply per state slot across
// all MAX_STATE_COUNT slots. A next nucleotide reads the chain ends, runs the
// recursion over the model states and then normalizes each state slot with the
// radix-2 divider, one state at a time; slots beyond the model skip the divider.
// Only one nucleotide request is in flight; loads are taken whenever the block is idle,
// also while a result waits on a stalled receiver. A stalled receiver holds the
// result register, and a finished nucleotide waits in its output step until the
// register frees. Reset (rst_n low, synchronous) returns to idle, one motif of
// width one; tables hold garbage until loaded, alpha until a first nucleotide.
module motif_hmm_forward_scaled #(
  parameter int MAX_STATE_COUNT = mhf_pkg::MAX_STATE_COUNT_DEF,
  parameter int MAX_MOTIF_COUNT = mhf_pkg::MAX_MOTIF_COUNT_DEF,
  parameter int FRAC_BITS       = mhf_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mhf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mhf_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mhf_pkg::IN_DW-1:0]   in_tdata,   // table_index, table_value, nucleotide
  input  logic [1:0]                  in_tuser,   // cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mhf_pkg::OUT_DW-1:0]  out_tdata,  // scale
  output logic                        out_tuser   // zero_scale
);
  import mhf_pkg::*;

  localparam int SIW = $clog2(MAX_STATE_COUNT);

  mhf_cmd_t       cmd;
  logic [SIW-1:0] st_idx, rd_idx;
  logic           sum_zero;

  mhf_ctrl #(.MSC(MAX_STATE_COUNT), .MMC(MAX_MOTIF_COUNT), .FB(FRAC_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_cmd(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sum_zero(sum_zero), .cmd(cmd), .st_idx(st_idx), .rd_idx(rd_idx)
  );

  mhf_dp #(.MSC(MAX_STATE_COUNT), .MMC(MAX_MOTIF_COUNT), .FB(FRAC_BITS)) u_dp (
    .clk(clk), .in_accept(in_tvalid && in_tready), .in_cmd(in_tuser),
    .in_tix(in_tdata[8:0]), .in_val(in_tdata[40:9]), .in_nuc(in_tdata[48:41]),
    .cmd(cmd), .st_idx(st_idx), .rd_idx(rd_idx), .sum_zero(sum_zero),
    .out_scale(out_tdata), .out_zero(out_tuser)
  );

endmodule
